/* rtl/padded_unsigned_decimal_formatter_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the padded unsigned decimal formatter
// Shared immediate-implication and next-cycle property wrappers, all clocked
// on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PADDED_UNSIGNED_DECIMAL_FORMATTER_ASSERT_SVH
`define PADDED_UNSIGNED_DECIMAL_FORMATTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PUDF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PUDF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pudf_pkg.sv */
// ---------------------------------------------------------------------------
// pudf_pkg
// Widths, character codes and shared types of the decimal formatter.
// ---------------------------------------------------------------------------
package pudf_pkg;

   localparam int VALUE_W           = 32;
   localparam int FIELD_W           = 7;
   localparam int CHAR_W            = 8;
   localparam int NUM_DIGITS        = 10;
   localparam int DIG_IDX_W         = $clog2(NUM_DIGITS);
   localparam int STEPS_PER_STAGE   = 8;
   localparam int NUM_DABBLE_STAGES = VALUE_W / STEPS_PER_STAGE;
   localparam int DEFAULT_MAX_FIELD = 64;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef logic [NUM_DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic zero_pad;
      logic left_align;
   } fmt_flags_type;

endpackage

/* rtl/pudf_dabble.sv */
// ---------------------------------------------------------------------------
// pudf_dabble
// One register stage of the binary to BCD converter: a fixed number of
// shift-and-add-three steps, with the field settings carried alongside.
// ---------------------------------------------------------------------------
module pudf_dabble
   import pudf_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [VALUE_W-1:0]  in_bin,
   input  bcd_type             in_bcd,
   input  logic [LEN_W-1:0]    in_width,
   input  logic [LEN_W-1:0]    in_prec,
   input  fmt_flags_type       in_flags,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [VALUE_W-1:0]  out_bin,
   output bcd_type             out_bcd,
   output logic [LEN_W-1:0]    out_width,
   output logic [LEN_W-1:0]    out_prec,
   output fmt_flags_type       out_flags
);

   logic                v_ff, v_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   bcd_type             bcd_ff, bcd_in;
   logic [LEN_W-1:0]    width_ff;
   logic [LEN_W-1:0]    prec_ff;
   fmt_flags_type       flags_ff;
   logic                load;

   always_comb begin
      bin_in = in_bin;
      bcd_in = in_bcd;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_in[d] >= 4'd5) begin
               bcd_in[d] = bcd_in[d] + 4'd3;
            end
         end
         {bcd_in, bin_in} = {bcd_in, bin_in} << 1;
      end
   end

   assign in_ready = !v_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bin_ff   <= bin_in;
         bcd_ff   <= bcd_in;
         width_ff <= in_width;
         prec_ff  <= in_prec;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = v_ff;
   assign out_bin   = bin_ff;
   assign out_bcd   = bcd_ff;
   assign out_width = width_ff;
   assign out_prec  = prec_ff;
   assign out_flags = flags_ff;

endmodule

/* rtl/pudf_size.sv */
// ---------------------------------------------------------------------------
// pudf_size
// Counts the significant digits and splits the field into leading pad,
// digit part and trailing pad, registering the job for the emitter.
// ---------------------------------------------------------------------------
module pudf_size
   import pudf_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bcd_type            in_bcd,
   input  logic [LEN_W-1:0]   in_width,
   input  logic [LEN_W-1:0]   in_prec,
   input  fmt_flags_type      in_flags,
   output logic               job_valid,
   input  logic               job_ready,
   output bcd_type            job_bcd,
   output logic [LEN_W-1:0]   job_pre,
   output logic [LEN_W-1:0]   job_dig,
   output logic [LEN_W-1:0]   job_post,
   output logic [LEN_W-1:0]   job_total,
   output logic               job_zero
);

   logic               v_ff, v_in;
   bcd_type            bcd_ff;
   logic [LEN_W-1:0]   pre_ff, pre_in;
   logic [LEN_W-1:0]   dig_ff, dig_in;
   logic [LEN_W-1:0]   post_ff, post_in;
   logic [LEN_W-1:0]   total_ff, total_in;
   logic               zero_ff;
   logic [LEN_W-1:0]   ndig;
   logic [LEN_W-1:0]   padn;
   logic               load;

   // Zero still has one digit, so the count never drops below one.
   always_comb begin
      ndig = LEN_W'(1);
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (in_bcd[d] != 4'd0) begin
            ndig = LEN_W'(d + 1);
         end
      end
   end

   always_comb begin
      dig_in   = (in_prec > ndig) ? in_prec : ndig;
      padn     = (in_width > dig_in) ? (in_width - dig_in) : '0;
      total_in = dig_in + padn;
      pre_in   = in_flags.left_align ? '0 : padn;
      post_in  = in_flags.left_align ? padn : '0;
   end

   assign in_ready = !v_ff || job_ready;
   assign load     = in_valid && in_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bcd_ff   <= in_bcd;
         pre_ff   <= pre_in;
         dig_ff   <= dig_in;
         post_ff  <= post_in;
         total_ff <= total_in;
         zero_ff  <= in_flags.zero_pad;
      end
   end

   assign job_valid = v_ff;
   assign job_bcd   = bcd_ff;
   assign job_pre   = pre_ff;
   assign job_dig   = dig_ff;
   assign job_post  = post_ff;
   assign job_total = total_ff;
   assign job_zero  = zero_ff;

endmodule

/* rtl/pudf_emit.sv */
// ---------------------------------------------------------------------------
// pudf_emit
// Character sequencer: walks leading pad, digit part and trailing pad of
// one job, one character per cycle, into the registered result port.
// ---------------------------------------------------------------------------
module pudf_emit
   import pudf_pkg::*;
#(
   parameter int LEN_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  bcd_type             job_bcd,
   input  logic [LEN_W-1:0]    job_pre,
   input  logic [LEN_W-1:0]    job_dig,
   input  logic [LEN_W-1:0]    job_post,
   input  logic [LEN_W-1:0]    job_total,
   input  logic                job_zero,
   output logic                rsp_strobe,
   output logic [CHAR_W-1:0]   rsp_out_char,
   output logic                rsp_last_char,
   output logic [FIELD_W-1:0]  rsp_total_length
);

   logic                act_ff, act_in;
   bcd_type             bcd_ff;
   logic [LEN_W-1:0]    pre_ff, pre_in;
   logic [LEN_W-1:0]    dig_ff, dig_in;
   logic [LEN_W-1:0]    post_ff, post_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [LEN_W-1:0]    total_ff;
   logic                zero_ff;
   logic                strobe_ff;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff;
   logic [FIELD_W-1:0]  length_ff;
   logic [CHAR_W-1:0]   pad_char;
   logic [LEN_W-1:0]    dig_pos;
   logic                final_char;
   logic                load;

   assign final_char = act_ff && (rem_ff == LEN_W'(1));
   assign job_ready  = !act_ff || final_char;
   assign load       = job_valid && job_ready;
   assign pad_char   = zero_ff ? CHAR_ZERO : CHAR_SPACE;
   assign dig_pos    = dig_ff - LEN_W'(1);

   // Digit positions above the significant ones read as zero nibbles,
   // which gives the precision zeros for free.
   always_comb begin
      pre_in  = pre_ff;
      dig_in  = dig_ff;
      post_in = post_ff;
      rem_in  = rem_ff - LEN_W'(1);
      char_in = pad_char;
      if (pre_ff != '0) begin
         pre_in = pre_ff - LEN_W'(1);
      end else if (dig_ff != '0) begin
         dig_in = dig_ff - LEN_W'(1);
         if (dig_pos < LEN_W'(NUM_DIGITS)) begin
            char_in = CHAR_ZERO + {4'b0000, bcd_ff[dig_pos[DIG_IDX_W-1:0]]};
         end else begin
            char_in = CHAR_ZERO;
         end
      end else begin
         post_in = post_ff - LEN_W'(1);
      end
   end

   always_comb begin
      if (load) begin
         act_in = 1'b1;
      end else if (final_char) begin
         act_in = 1'b0;
      end else begin
         act_in = act_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         act_ff    <= act_in;
         strobe_ff <= act_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bcd_ff   <= job_bcd;
         pre_ff   <= job_pre;
         dig_ff   <= job_dig;
         post_ff  <= job_post;
         rem_ff   <= job_total;
         total_ff <= job_total;
         zero_ff  <= job_zero;
      end else if (act_ff) begin
         pre_ff  <= pre_in;
         dig_ff  <= dig_in;
         post_ff <= post_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      last_ff   <= final_char;
      length_ff <= FIELD_W'(total_ff);
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_last_char    = last_ff;
   assign rsp_total_length = length_ff;

   `include "padded_unsigned_decimal_formatter_assert.svh"

   `PUDF_ASSERT_NEXT(a_chars_contiguous, rsp_strobe && !rsp_last_char, rsp_strobe,
      "characters of one number must leave on consecutive cycles")
   `PUDF_ASSERT_NOW(a_rem_split, act_ff, rem_ff == pre_ff + dig_ff + post_ff,
      "remaining count out of step with the pad and digit counters")
   `PUDF_ASSERT_NOW(a_rem_nonzero, act_ff, rem_ff != '0,
      "active job with nothing left to send")
   `PUDF_ASSERT_NOW(a_length_nonzero, rsp_strobe, rsp_total_length != '0,
      "result transfer carries an empty total length")

endmodule

/* rtl/padded_unsigned_decimal_formatter.sv */
// ---------------------------------------------------------------------------
// padded_unsigned_decimal_formatter
// Formats an unsigned 32-bit value as padded decimal text, one character
// per result transfer.
// ---------------------------------------------------------------------------
// A number is accepted when start is high and busy is low. Its text leaves
// on rsp_strobe as one character per cycle, max(digits, width, precision)
// characters on consecutive cycles, the final one marked by rsp_last_char;
// the receiver must take every character as it comes. The character
// sequencer sets the sustained rate of numbers, which follows each number's
// total length, between 1 and MAX_FIELD. Conversion runs through a
// four-stage BCD pipeline and a sizing stage, and up to five further
// numbers are taken and held while one is being sent.
// ---------------------------------------------------------------------------
module padded_unsigned_decimal_formatter
   import pudf_pkg::*;
#(
   parameter int MAX_FIELD = DEFAULT_MAX_FIELD
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [FIELD_W-1:0]  req_min_width,
   input  logic [FIELD_W-1:0]  req_precision,
   input  logic                req_zero_pad,
   input  logic                req_left_align,
   output logic                rsp_strobe,
   output logic [CHAR_W-1:0]   rsp_out_char,
   output logic                rsp_last_char,
   output logic [FIELD_W-1:0]  rsp_total_length
);

   localparam int LEN_W = $clog2(MAX_FIELD + 1);
   localparam int SAT_W = (LEN_W > FIELD_W) ? LEN_W : FIELD_W;

   logic [SAT_W-1:0]    width_ext, prec_ext;
   logic [SAT_W-1:0]    width_sat, prec_sat;

   logic                st_valid [NUM_DABBLE_STAGES+1];
   logic                st_ready [NUM_DABBLE_STAGES+1];
   logic [VALUE_W-1:0]  st_bin   [NUM_DABBLE_STAGES+1];
   bcd_type             st_bcd   [NUM_DABBLE_STAGES+1];
   logic [LEN_W-1:0]    st_width [NUM_DABBLE_STAGES+1];
   logic [LEN_W-1:0]    st_prec  [NUM_DABBLE_STAGES+1];
   fmt_flags_type       st_flags [NUM_DABBLE_STAGES+1];

   logic                job_valid, job_ready;
   bcd_type             job_bcd;
   logic [LEN_W-1:0]    job_pre, job_dig, job_post, job_total;
   logic                job_zero;

   // Width and precision saturate at the field limit on the way in.
   assign width_ext = SAT_W'(req_min_width);
   assign prec_ext  = SAT_W'(req_precision);
   assign width_sat = (width_ext > SAT_W'(MAX_FIELD)) ? SAT_W'(MAX_FIELD) : width_ext;
   assign prec_sat  = (prec_ext > SAT_W'(MAX_FIELD)) ? SAT_W'(MAX_FIELD) : prec_ext;

   assign st_valid[0]            = start;
   assign st_bin[0]              = req_value;
   assign st_bcd[0]              = '0;
   assign st_width[0]            = LEN_W'(width_sat);
   assign st_prec[0]             = LEN_W'(prec_sat);
   assign st_flags[0].zero_pad   = req_zero_pad;
   assign st_flags[0].left_align = req_left_align;
   assign busy                   = !st_ready[0];

   for (genvar g = 0; g < NUM_DABBLE_STAGES; g++) begin : g_dabble
      pudf_dabble #(
         .LEN_W (LEN_W)
      ) u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[g]),
         .in_ready  (st_ready[g]),
         .in_bin    (st_bin[g]),
         .in_bcd    (st_bcd[g]),
         .in_width  (st_width[g]),
         .in_prec   (st_prec[g]),
         .in_flags  (st_flags[g]),
         .out_valid (st_valid[g+1]),
         .out_ready (st_ready[g+1]),
         .out_bin   (st_bin[g+1]),
         .out_bcd   (st_bcd[g+1]),
         .out_width (st_width[g+1]),
         .out_prec  (st_prec[g+1]),
         .out_flags (st_flags[g+1])
      );
   end

   pudf_size #(
      .LEN_W (LEN_W)
   ) u_size (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[NUM_DABBLE_STAGES]),
      .in_ready  (st_ready[NUM_DABBLE_STAGES]),
      .in_bcd    (st_bcd[NUM_DABBLE_STAGES]),
      .in_width  (st_width[NUM_DABBLE_STAGES]),
      .in_prec   (st_prec[NUM_DABBLE_STAGES]),
      .in_flags  (st_flags[NUM_DABBLE_STAGES]),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_bcd   (job_bcd),
      .job_pre   (job_pre),
      .job_dig   (job_dig),
      .job_post  (job_post),
      .job_total (job_total),
      .job_zero  (job_zero)
   );

   pudf_emit #(
      .LEN_W (LEN_W)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job_ready        (job_ready),
      .job_bcd          (job_bcd),
      .job_pre          (job_pre),
      .job_dig          (job_dig),
      .job_post         (job_post),
      .job_total        (job_total),
      .job_zero         (job_zero),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char),
      .rsp_total_length (rsp_total_length)
   );

endmodule
